// File: rtl/core/tas_pkg.sv
package tas_pkg;

	// Atlas and slot table sizing
	localparam int ATLAS_EDGE = 2048;
	localparam int SLOT_COUNT = 32;

	// Field widths of the request and result ports
	localparam int KEY_W      = 32;
	localparam int SIZE_W     = 12;
	localparam int SLOT_IDX_W = 5;
	localparam int POS_W      = 12;

	// Stored coordinates hold 0..ATLAS_EDGE
	localparam int COORD_W = $clog2(ATLAS_EDGE + 1);
	// One extra bit for coordinate plus size sums
	localparam int SUM_W   = ((COORD_W > SIZE_W) ? COORD_W : SIZE_W) + 1;
	// Slot address and fill count
	localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int FILL_W  = $clog2(SLOT_COUNT + 1);

	typedef enum logic [2:0] {
		STATUS_HIT        = 3'd0,
		STATUS_PLACED     = 3'd1,
		STATUS_TABLE_FULL = 3'd2,
		STATUS_TOO_LARGE  = 3'd3,
		STATUS_ATLAS_FULL = 3'd4
	} status_t;

	// One slot table entry
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} slot_entry_t;

endpackage

// File: rtl/core/texture_atlas_shelf_allocator_core.sv
// Channel   Ports                                         Transfer
// request   image_key, image_width, image_height          in_valid & in_ready
// result    status, slot_index, place_x, place_y          out_valid & out_ready
//
// One request at a time. A request passes through accept, a scan that streams the slot
// table memory past the key compare (one entry per cycle through the single read
// port), place, and a load of the output register; a hit ends the scan early and
// skips the place step.
// Slots fill from index 0 and are never freed, so a fill count stands in for the
// used bits; reset clears it and the cursors at once, no clearing pass.
// A result waiting on out_ready holds the block in its emit step; in_ready is
// high only between requests.
module texture_atlas_shelf_allocator_core
	import tas_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [KEY_W-1:0]      image_key,
	input  logic [SIZE_W-1:0]     image_width,
	input  logic [SIZE_W-1:0]     image_height,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic [SLOT_IDX_W-1:0] slot_index,
	output logic [POS_W-1:0]      place_x,
	output logic [POS_W-1:0]      place_y
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PLACE, ST_EMIT} state_t;

	state_t             state_q;
	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  issue_q;
	logic               pend_s1;
	logic [SLOT_AW-1:0] pidx_s1;
	logic [COORD_W-1:0] cursor_x_q;
	logic [COORD_W-1:0] cursor_y_q;
	logic [COORD_W-1:0] shelf_q;
	logic [KEY_W-1:0]   key_q;
	logic [SIZE_W-1:0]  w_q;
	logic [SIZE_W-1:0]  h_q;
	status_t            res_status_q;
	logic [SLOT_AW-1:0] res_slot_q;
	logic [COORD_W-1:0] res_x_q;
	logic [COORD_W-1:0] res_y_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [SLOT_AW-1:0] out_slot_q;
	logic [COORD_W-1:0] out_x_q;
	logic [COORD_W-1:0] out_y_q;

	// Slot table memory
	logic               ram_we;
	logic               ram_re;
	slot_entry_t        ram_wdata;
	slot_entry_t        ram_rdata;
	logic [SLOT_AW-1:0] ram_waddr;
	logic [SLOT_AW-1:0] ram_raddr;

	tas_ram #(
		.WIDTH($bits(slot_entry_t)),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Scan control
	logic scan_hit;
	logic scan_done;

	assign ram_re    = (state_q == ST_SCAN) && (issue_q != fill_q);
	assign ram_raddr = issue_q[SLOT_AW-1:0];
	assign scan_hit  = (state_q == ST_SCAN) && pend_s1 && (ram_rdata.key == key_q);
	assign scan_done = (state_q == ST_SCAN) && !pend_s1 && (issue_q == fill_q);

	// Placement decision
	logic [SUM_W-1:0]   x_end;
	logic [SUM_W-1:0]   y_end;
	logic               wrap;
	logic               table_full;
	logic               too_large;
	logic               atlas_full;
	logic [COORD_W-1:0] new_cx;
	logic [COORD_W-1:0] new_cy;
	logic [COORD_W-1:0] new_sh;
	logic               place_ok;

	always_comb begin
		table_full = (fill_q == FILL_W'(SLOT_COUNT));
		too_large  = (SUM_W'(w_q) > SUM_W'(ATLAS_EDGE)) || (SUM_W'(h_q) > SUM_W'(ATLAS_EDGE));
		x_end      = SUM_W'(cursor_x_q) + SUM_W'(w_q);
		wrap       = x_end > SUM_W'(ATLAS_EDGE);
		new_cx     = wrap ? '0 : cursor_x_q;
		new_cy     = wrap ? COORD_W'(SUM_W'(cursor_y_q) + SUM_W'(shelf_q)) : cursor_y_q;
		new_sh     = wrap ? '0 : shelf_q;
		y_end      = SUM_W'(new_cy) + SUM_W'(h_q);
		atlas_full = y_end > SUM_W'(ATLAS_EDGE);
		place_ok   = (state_q == ST_PLACE) && !table_full && !too_large && !atlas_full;
	end

	assign ram_we          = place_ok;
	assign ram_waddr       = fill_q[SLOT_AW-1:0];
	assign ram_wdata.key   = key_q;
	assign ram_wdata.x     = new_cx;
	assign ram_wdata.y     = new_cy;

	// Sequencer, table state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			issue_q     <= '0;
			pend_s1     <= 1'b0;
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			shelf_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the emit step reloads the output register itself
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q   <= image_key;
						w_q     <= image_width;
						h_q     <= image_height;
						issue_q <= '0;
						pend_s1 <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_s1 <= ram_re;
					pidx_s1 <= issue_q[SLOT_AW-1:0];
					if (ram_re) begin
						issue_q <= issue_q + FILL_W'(1);
					end
					if (scan_hit) begin
						res_status_q <= STATUS_HIT;
						res_slot_q   <= pidx_s1;
						res_x_q      <= ram_rdata.x;
						res_y_q      <= ram_rdata.y;
						state_q      <= ST_EMIT;
					end else if (scan_done) begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					if (place_ok) begin
						res_status_q <= STATUS_PLACED;
						res_slot_q   <= fill_q[SLOT_AW-1:0];
						res_x_q      <= new_cx;
						res_y_q      <= new_cy;
						fill_q       <= fill_q + FILL_W'(1);
						cursor_x_q   <= COORD_W'(SUM_W'(new_cx) + SUM_W'(w_q));
						cursor_y_q   <= new_cy;
						shelf_q      <= (SUM_W'(h_q) > SUM_W'(new_sh)) ? COORD_W'(h_q) : new_sh;
					end else begin
						res_slot_q <= '0;
						res_x_q    <= '0;
						res_y_q    <= '0;
						if (table_full) begin
							res_status_q <= STATUS_TABLE_FULL;
						end else if (too_large) begin
							res_status_q <= STATUS_TOO_LARGE;
						end else begin
							// shelf wrap stands even when the image then misses vertically
							res_status_q <= STATUS_ATLAS_FULL;
							cursor_x_q   <= new_cx;
							cursor_y_q   <= new_cy;
							shelf_q      <= new_sh;
						end
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						out_x_q      <= res_x_q;
						out_y_q      <= res_y_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign slot_index = SLOT_IDX_W'(out_slot_q);
	assign place_x    = POS_W'(out_x_q);
	assign place_y    = POS_W'(out_y_q);

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(SLOT_COUNT))
		else $error("slot fill count beyond table size");

	a_write_grows_fill: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("slot write without fill count step");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(cursor_x_q) <= SUM_W'(ATLAS_EDGE)
		&& (SUM_W'(cursor_y_q) + SUM_W'(shelf_q)) <= SUM_W'(ATLAS_EDGE))
		else $error("cursor left the atlas");

	a_scan_within_fill: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (issue_q < fill_q))
		else $error("scan read beyond used slots");

	a_result_waits_for_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_valid_q && !out_ready) |=> (state_q == ST_EMIT))
		else $error("result dropped while output register busy");

endmodule

// File: rtl/core/tas_ram.sv
module tas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
